>>> sv/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [1:0] {
        CMD_CPU_RD = 2'd0,
        CMD_CPU_WR = 2'd1,
        CMD_PPU_RD = 2'd2,
        CMD_PPU_WR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        TGT_OPEN  = 3'd0,
        TGT_LATCH = 3'd1,
        TGT_PRAM  = 3'd2,
        TGT_PROM  = 3'd3,
        TGT_NT    = 3'd4,
        TGT_CROM  = 3'd5,
        TGT_CRAM  = 3'd6,
        TGT_ZERO  = 3'd7
    } target_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_A0_LINE   = 3'd0,
        CFG_A1_LINE   = 3'd1,
        CFG_HAS_PRAM  = 3'd2,
        CFG_PROM_BANKS = 3'd3,
        CFG_HAS_CROM  = 3'd4,
        CFG_HAS_CRAM  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [17:0] mem_address;
        logic        is_write;
        logic [7:0]  data_out;
        logic        latch_value;
    } rsp_t;

    typedef struct packed {
        logic [2:0] a0_line;
        logic [2:0] a1_line;
        logic       has_prg_ram;
        logic [4:0] prg_rom_banks;
        logic       has_chr_rom;
        logic       has_chr_ram;
    } cfg_t;

    typedef struct packed {
        logic [1:0][4:0] prog_bank;
        logic [7:0][7:0] char_bank;
        logic [1:0]      mirror_mode;
        logic            latch_bit;
    } map_state_t;

    // Register-file update requested by one access
    typedef struct packed {
        logic       prg0_we;
        logic       prg1_we;
        logic       mirror_we;
        logic       chr_we;
        logic [2:0] chr_idx;
        logic       chr_hi;
        logic       latch_we;
        logic [7:0] data;
    } upd_t;

endpackage

`default_nettype wire

>>> sv/cbm_if.sv
`default_nettype none

interface cbm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] bus_address;
    logic [7:0]  write_data;

    modport source (output valid, output cmd, output bus_address, output write_data,
                    input ready);
    modport sink   (input valid, input cmd, input bus_address, input write_data,
                    output ready);
endinterface

interface cbm_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [17:0] mem_address;
    logic        is_write;
    logic [7:0]  data_out;
    logic        latch_value;

    modport source (output valid, output target, output mem_address, output is_write,
                    output data_out, output latch_value, input ready);
    modport sink   (input valid, input target, input mem_address, input is_write,
                    input data_out, input latch_value, output ready);
endinterface

interface cbm_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] addr;
    logic [7:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

>>> sv/cbm_bank_regs.sv
`default_nettype none

module cbm_bank_regs
    import cbm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  fire,
    input  wire upd_t                  upd,
    output cfg_t                       cfg,
    output map_state_t                 st
);

    cfg_t       cfg_reg, cfg_next;
    map_state_t st_reg, st_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_A0_LINE:    cfg_next.a0_line       = cfg_data[2:0];
                CFG_A1_LINE:    cfg_next.a1_line       = cfg_data[2:0];
                CFG_HAS_PRAM:   cfg_next.has_prg_ram   = cfg_data[0];
                CFG_PROM_BANKS: cfg_next.prg_rom_banks = cfg_data[4:0];
                CFG_HAS_CROM:   cfg_next.has_chr_rom   = cfg_data[0];
                CFG_HAS_CRAM:   cfg_next.has_chr_ram   = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        st_next = st_reg;
        if (fire)
        begin
            if (upd.prg0_we)
                st_next.prog_bank[0] = upd.data[4:0];
            if (upd.prg1_we)
                st_next.prog_bank[1] = upd.data[4:0];
            if (upd.mirror_we)
                st_next.mirror_mode = upd.data[1:0];
            if (upd.latch_we)
                st_next.latch_bit = upd.data[0];
            // Character banks load one nibble per write
            if (upd.chr_we)
            begin
                if (upd.chr_hi)
                    st_next.char_bank[upd.chr_idx][7:4] = upd.data[3:0];
                else
                    st_next.char_bank[upd.chr_idx][3:0] = upd.data[3:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg               <= '{a1_line: 3'd1, default: '0};
            st_reg                <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            st_reg  <= st_next;
        end
    end

    assign cfg = cfg_reg;
    assign st  = st_reg;

endmodule

`default_nettype wire

>>> sv/cbm_translate.sv
`default_nettype none

module cbm_translate
    import cbm_pkg::*;
(
    input  wire req_t       req,
    input  wire cfg_t       cfg,
    input  wire map_state_t st,
    output rsp_t            rsp,
    output upd_t            upd
);

    localparam logic [3:0] PAGE_PRG0      = 4'h8;
    localparam logic [3:0] PAGE_MIRROR    = 4'h9;
    localparam logic [3:0] PAGE_PRG1      = 4'hA;
    localparam logic [3:0] PAGE_CHR_FIRST = 4'hB;
    localparam logic [3:0] PAGE_CHR_LAST  = 4'hE;

    localparam logic [1:0] MIR_VERTICAL   = 2'd0;
    localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
    localparam logic [1:0] MIR_SINGLE_LO  = 2'd2;

    always_comb
    begin
        logic [15:0] a;
        logic        cpu;
        logic        wr_cmd;
        logic [3:0]  page;
        logic        s0;
        logic        s1;
        logic [3:0]  chr_off;
        logic [4:0]  bank;
        logic [7:0]  cbank;
        logic [10:0] nt_addr;

        a       = req.bus_address;
        cpu     = (req.cmd == CMD_CPU_RD) || (req.cmd == CMD_CPU_WR);
        wr_cmd  = (req.cmd == CMD_CPU_WR) || (req.cmd == CMD_PPU_WR);
        page    = a[15:12];
        s0      = a[cfg.a0_line];
        s1      = a[cfg.a1_line];
        chr_off = page - PAGE_CHR_FIRST;
        cbank   = st.char_bank[a[12:10]];

        case (a[14:13])
            2'd0:    bank = st.prog_bank[0];
            2'd1:    bank = st.prog_bank[1];
            2'd2:    bank = cfg.prg_rom_banks - 5'd2;
            default: bank = cfg.prg_rom_banks - 5'd1;
        endcase

        case (st.mirror_mode)
            MIR_VERTICAL:   nt_addr = {a[10], a[9:0]};
            MIR_HORIZONTAL: nt_addr = {a[11], a[9:0]};
            MIR_SINGLE_LO:  nt_addr = {1'b0, a[9:0]};
            default:        nt_addr = {1'b1, a[9:0]};
        endcase

        rsp.target      = TGT_OPEN;
        rsp.mem_address = '0;
        rsp.is_write    = 1'b0;
        upd             = '0;
        upd.data        = req.write_data;
        upd.chr_idx     = {chr_off[1:0], s1};
        upd.chr_hi      = s0;

        if (cpu)
        begin
            if (a[15])
            begin
                if (wr_cmd)
                begin
                    upd.prg0_we   = (page == PAGE_PRG0);
                    upd.mirror_we = (page == PAGE_MIRROR);
                    upd.prg1_we   = (page == PAGE_PRG1);
                    upd.chr_we    = (page >= PAGE_CHR_FIRST) && (page <= PAGE_CHR_LAST);
                end
                else
                begin
                    rsp.target      = TGT_PROM;
                    rsp.mem_address = {bank, a[12:0]};
                end
            end
            else if (a[14:13] == 2'b11)
            begin
                if (cfg.has_prg_ram)
                begin
                    rsp.target      = TGT_PRAM;
                    rsp.mem_address = {5'd0, a[12:0]};
                    rsp.is_write    = wr_cmd;
                end
                else if (!a[12])
                begin
                    // Without save RAM the low half holds a one-bit latch
                    if (wr_cmd)
                        upd.latch_we = 1'b1;
                    else
                        rsp.target = TGT_LATCH;
                end
            end
        end
        else if (a[13])
        begin
            rsp.target      = TGT_NT;
            rsp.mem_address = {7'd0, nt_addr};
            rsp.is_write    = wr_cmd;
        end
        else if (wr_cmd)
        begin
            if (cfg.has_chr_ram)
            begin
                rsp.target      = TGT_CRAM;
                rsp.mem_address = {cbank, a[9:0]};
                rsp.is_write    = 1'b1;
            end
        end
        else if (cfg.has_chr_rom)
        begin
            rsp.target      = TGT_CROM;
            rsp.mem_address = {cbank, a[9:0]};
        end
        else if (cfg.has_chr_ram)
        begin
            rsp.target      = TGT_CRAM;
            rsp.mem_address = {cbank, a[9:0]};
        end
        else
        begin
            rsp.target = TGT_ZERO;
        end

        rsp.data_out    = rsp.is_write ? req.write_data : 8'd0;
        rsp.latch_value = upd.latch_we ? req.write_data[0] : st.latch_bit;
    end

endmodule

`default_nettype wire

>>> sv/cartridge_bank_mapper_core.sv
// Bank-switching cartridge mapper: translates one CPU or PPU bus access per word on req into
// a target memory and address on rsp. Each access is registered on entry, decoded
// combinationally against the bank registers and registered again on exit, and one word is
// taken every cycle while rsp keeps draining. Bank, mirroring and latch updates take effect
// in access order: an access sees every update made by earlier ones.
// Configuration words on cfg are always taken and should be written while the block is idle.
`default_nettype none

module cartridge_bank_mapper_core
    import cbm_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    cbm_cfg_if.sink   cfg,
    cbm_req_if.sink   req,
    cbm_rsp_if.source rsp
);

    logic       in_vld_reg, in_vld_next;
    req_t       in_word_reg;
    logic       out_vld_reg, out_vld_next;
    rsp_t       out_word_reg;

    logic       out_free;
    logic       fire;
    logic       take;
    cfg_t       cur_cfg;
    map_state_t cur_st;
    rsp_t       xl_rsp;
    upd_t       xl_upd;

    assign out_free  = !out_vld_reg || rsp.ready;
    assign fire      = in_vld_reg && out_free;
    assign req.ready = !in_vld_reg || out_free;
    assign take      = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    cbm_bank_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg.valid),
        .cfg_addr (cfg.addr),
        .cfg_data (cfg.data),
        .fire     (fire),
        .upd      (xl_upd),
        .cfg      (cur_cfg),
        .st       (cur_st)
    );

    cbm_translate u_xlate (
        .req (in_word_reg),
        .cfg (cur_cfg),
        .st  (cur_st),
        .rsp (xl_rsp),
        .upd (xl_upd)
    );

    always_comb
    begin
        in_vld_next  = take || (in_vld_reg && !fire);
        out_vld_next = fire || (out_vld_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers: hold unless a new word moves in
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_word_reg.cmd         <= req.cmd;
            in_word_reg.bus_address <= req.bus_address;
            in_word_reg.write_data  <= req.write_data;
        end
        if (fire)
            out_word_reg <= xl_rsp;
    end

    assign rsp.valid       = out_vld_reg;
    assign rsp.target      = out_word_reg.target;
    assign rsp.mem_address = out_word_reg.mem_address;
    assign rsp.is_write    = out_word_reg.is_write;
    assign rsp.data_out    = out_word_reg.data_out;
    assign rsp.latch_value = out_word_reg.latch_value;

endmodule

`default_nettype wire

>>> sv/cbm_checker.sv
`default_nettype none

module cbm_checker
    import cbm_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [2:0]  rsp_target,
    input wire logic [17:0] rsp_mem_address,
    input wire logic        rsp_is_write,
    input wire logic [7:0]  rsp_data_out
);

    // Stalled result word must hold
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_target)
            && $stable(rsp_mem_address) && $stable(rsp_data_out))
        else $error("result word changed while stalled");

    // Accepted word reaches the output, through the input and output registers, when the output drains
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid)
        else $error("accepted word did not reach the output");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_is_write |-> rsp_data_out == 8'd0)
        else $error("data driven on a non-write result");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_is_write |->
            rsp_target == TGT_PRAM || rsp_target == TGT_NT || rsp_target == TGT_CRAM)
        else $error("write to a read-only or absent target");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_target == TGT_OPEN || rsp_target == TGT_LATCH
            || rsp_target == TGT_ZERO) |-> rsp_mem_address == 18'd0 && !rsp_is_write)
        else $error("address or write on a target with no memory");

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_target      (rsp.target),
    .rsp_mem_address (rsp.mem_address),
    .rsp_is_write    (rsp.is_write),
    .rsp_data_out    (rsp.data_out)
);

`default_nettype wire
